// ----- rtl/ttq_pkg.sv -----
`default_nettype none
package ttq_pkg;

    localparam int TILE_ID_W   = 13;
    localparam int CELL_W      = 6;
    localparam int PRIO_W      = 3;
    localparam int TS_W        = 5;
    localparam int KINDS_W     = 14;
    localparam int PCOUNT_W    = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;

    localparam int DEF_MAX_TILE_IDS = 8192;
    localparam int DEF_MAX_CELLS    = 64;

    localparam logic [TILE_ID_W-1:0] AUTOTILE_FIRST = 13'd48;
    localparam logic [TILE_ID_W-1:0] TILESET_FIRST  = 13'd384;
    localparam logic [PRIO_W-1:0]    PRIO_HIDDEN    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_COUNT = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_EXPAND = 1'b1;

    typedef enum logic [1:0] {
        KIND_ABSENT   = 2'd0,
        KIND_ANIMATED = 2'd1,
        KIND_STATIC   = 2'd2,
        KIND_STRIP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SHAPE_QUARTERS = 2'd0,
        SHAPE_STRIP    = 2'd1,
        SHAPE_TILESET  = 2'd2
    } shape_t;

    // Item after decode, before the priority read resolves
    typedef struct packed {
        logic [TILE_ID_W-1:0] id;
        logic [CELL_W-1:0]    cx;
        logic [CELL_W-1:0]    cy;
        logic                 use_prio;
        shape_t               shape;
        logic                 shift_static;
        logic [2:0]           slot;
        logic [5:0]           pat;
        logic [9:0]           trow;
        logic [2:0]           tcol;
    } dec_t;

    // Item ready for quad emission, with products already formed
    typedef struct packed {
        logic                 ground;
        logic [6:0]           layer;
        shape_t               shape;
        logic                 shift_static;
        logic [5:0]           pat;
        logic [11:0]          bx;
        logic [11:0]          by;
        logic [TS_W-1:0]      ts;
        logic [15:0]          yoff;
        logic [15:0]          tyrow;
        logic [9:0]           txcol;
    } quad_src_t;

    // Corner table in half-tile units, packed as LTx LTy RTx RTy LBx LBy RBx RBy
    function automatic logic [23:0] corner_row(input logic [5:0] p);
        logic [23:0] r;
        unique case (p)
            6'd0:  r = {3'd2,3'd4,3'd3,3'd4,3'd2,3'd5,3'd3,3'd5};
            6'd1:  r = {3'd4,3'd0,3'd3,3'd4,3'd2,3'd5,3'd3,3'd5};
            6'd2:  r = {3'd2,3'd4,3'd5,3'd0,3'd2,3'd5,3'd3,3'd5};
            6'd3:  r = {3'd4,3'd0,3'd5,3'd0,3'd2,3'd5,3'd3,3'd5};
            6'd4:  r = {3'd2,3'd4,3'd3,3'd4,3'd2,3'd5,3'd5,3'd1};
            6'd5:  r = {3'd4,3'd0,3'd3,3'd4,3'd2,3'd5,3'd5,3'd1};
            6'd6:  r = {3'd2,3'd4,3'd5,3'd0,3'd2,3'd5,3'd5,3'd1};
            6'd7:  r = {3'd4,3'd0,3'd5,3'd0,3'd2,3'd5,3'd5,3'd1};
            6'd8:  r = {3'd2,3'd4,3'd3,3'd4,3'd4,3'd1,3'd3,3'd5};
            6'd9:  r = {3'd4,3'd0,3'd3,3'd4,3'd4,3'd1,3'd3,3'd5};
            6'd10: r = {3'd2,3'd4,3'd5,3'd0,3'd4,3'd1,3'd3,3'd5};
            6'd11: r = {3'd4,3'd0,3'd5,3'd0,3'd4,3'd1,3'd3,3'd5};
            6'd12: r = {3'd2,3'd4,3'd3,3'd4,3'd4,3'd1,3'd5,3'd1};
            6'd13: r = {3'd4,3'd0,3'd3,3'd4,3'd4,3'd1,3'd5,3'd1};
            6'd14: r = {3'd2,3'd4,3'd5,3'd0,3'd4,3'd1,3'd5,3'd1};
            6'd15: r = {3'd4,3'd0,3'd5,3'd0,3'd4,3'd1,3'd5,3'd1};
            6'd16: r = {3'd0,3'd4,3'd1,3'd4,3'd0,3'd5,3'd1,3'd5};
            6'd17: r = {3'd0,3'd4,3'd5,3'd0,3'd0,3'd5,3'd1,3'd5};
            6'd18: r = {3'd0,3'd4,3'd1,3'd4,3'd0,3'd5,3'd5,3'd1};
            6'd19: r = {3'd0,3'd4,3'd5,3'd0,3'd0,3'd5,3'd5,3'd1};
            6'd20: r = {3'd2,3'd2,3'd3,3'd2,3'd2,3'd3,3'd3,3'd3};
            6'd21: r = {3'd2,3'd2,3'd3,3'd2,3'd2,3'd3,3'd5,3'd1};
            6'd22: r = {3'd2,3'd2,3'd3,3'd2,3'd4,3'd1,3'd3,3'd3};
            6'd23: r = {3'd2,3'd2,3'd3,3'd2,3'd4,3'd1,3'd5,3'd1};
            6'd24: r = {3'd4,3'd4,3'd5,3'd4,3'd4,3'd5,3'd5,3'd5};
            6'd25: r = {3'd4,3'd4,3'd5,3'd4,3'd4,3'd1,3'd5,3'd5};
            6'd26: r = {3'd4,3'd0,3'd5,3'd4,3'd4,3'd5,3'd5,3'd5};
            6'd27: r = {3'd4,3'd0,3'd5,3'd4,3'd4,3'd1,3'd5,3'd5};
            6'd28: r = {3'd2,3'd6,3'd3,3'd6,3'd2,3'd7,3'd3,3'd7};
            6'd29: r = {3'd4,3'd0,3'd3,3'd6,3'd2,3'd7,3'd3,3'd7};
            6'd30: r = {3'd2,3'd6,3'd5,3'd0,3'd2,3'd7,3'd3,3'd7};
            6'd31: r = {3'd4,3'd0,3'd5,3'd0,3'd2,3'd7,3'd3,3'd7};
            6'd32: r = {3'd0,3'd4,3'd5,3'd4,3'd0,3'd5,3'd5,3'd5};
            6'd33: r = {3'd2,3'd2,3'd3,3'd2,3'd2,3'd7,3'd3,3'd7};
            6'd34: r = {3'd0,3'd2,3'd1,3'd2,3'd0,3'd3,3'd1,3'd3};
            6'd35: r = {3'd0,3'd2,3'd1,3'd2,3'd0,3'd3,3'd5,3'd1};
            6'd36: r = {3'd4,3'd2,3'd5,3'd2,3'd4,3'd3,3'd5,3'd3};
            6'd37: r = {3'd4,3'd2,3'd5,3'd2,3'd4,3'd1,3'd5,3'd3};
            6'd38: r = {3'd4,3'd6,3'd5,3'd6,3'd4,3'd7,3'd5,3'd7};
            6'd39: r = {3'd4,3'd0,3'd5,3'd6,3'd4,3'd7,3'd5,3'd7};
            6'd40: r = {3'd0,3'd6,3'd1,3'd6,3'd0,3'd7,3'd1,3'd7};
            6'd41: r = {3'd0,3'd6,3'd5,3'd0,3'd0,3'd7,3'd1,3'd7};
            6'd42: r = {3'd0,3'd2,3'd5,3'd2,3'd0,3'd3,3'd5,3'd3};
            6'd43: r = {3'd0,3'd2,3'd1,3'd2,3'd0,3'd7,3'd1,3'd7};
            6'd44: r = {3'd0,3'd6,3'd5,3'd6,3'd0,3'd7,3'd5,3'd7};
            6'd45: r = {3'd4,3'd2,3'd5,3'd2,3'd4,3'd7,3'd5,3'd7};
            6'd46: r = {3'd0,3'd2,3'd5,3'd2,3'd0,3'd7,3'd5,3'd7};
            6'd47: r = {3'd0,3'd0,3'd1,3'd0,3'd0,3'd1,3'd1,3'd1};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ttq_ram.sv -----
`default_nettype none
module ttq_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ttq_decode.sv -----
`default_nettype none
// Stage 1: classify the cell, split the id into slot/pattern or row/column.
module ttq_decode #(
    parameter int MAX_TILE_IDS = 8192,
    parameter int MAX_CELLS    = 64
) (
    input  wire logic                          req_type,
    input  wire logic [ttq_pkg::TILE_ID_W-1:0] tile_id,
    input  wire logic [ttq_pkg::CELL_W-1:0]    cell_x,
    input  wire logic [ttq_pkg::CELL_W-1:0]    cell_y,
    input  wire logic [ttq_pkg::KINDS_W-1:0]   kinds,
    input  wire logic [ttq_pkg::PCOUNT_W-1:0]  prio_count,
    output logic                               keep,
    output ttq_pkg::dec_t                      dec
);
    import ttq_pkg::*;

    logic [3:0]           q48;
    logic [5:0]           r48;
    logic [TILE_ID_W-1:0] t;
    kind_t                kind;
    logic                 cell_ok;
    logic [2:0]           slot;

    // id / 48 for ids below 384: compare against multiples of 48
    always_comb
    begin
        q48 = 4'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (tile_id >= TILE_ID_W'(48 * k))
            begin
                q48 = 4'(k);
            end
        end
        r48 = 6'(tile_id - TILE_ID_W'({q48, 5'd0} + {q48, 4'd0}));
    end

    always_comb
    begin
        t       = tile_id - TILESET_FIRST;
        slot    = 3'(q48 - 4'd1);
        kind    = kind_t'(2'(kinds >> {slot, 1'b0}));
        cell_ok = (32'(cell_x) < MAX_CELLS) && (32'(cell_y) < MAX_CELLS);

        dec.id           = tile_id;
        dec.cx           = cell_x;
        dec.cy           = cell_y;
        dec.use_prio     = ({1'b0, tile_id} < {1'b0, prio_count})
                           && (32'(tile_id) < MAX_TILE_IDS);
        dec.slot         = slot;
        dec.pat          = r48;
        dec.trow         = t[12:3];
        dec.tcol         = t[2:0];
        dec.shift_static = (kind == KIND_STATIC);
        if (tile_id >= TILESET_FIRST)
        begin
            dec.shape = SHAPE_TILESET;
        end
        else if (kind == KIND_STRIP)
        begin
            dec.shape = SHAPE_STRIP;
        end
        else
        begin
            dec.shape = SHAPE_QUARTERS;
        end

        keep = (req_type == REQ_EXPAND) && cell_ok && (tile_id >= AUTOTILE_FIRST)
               && !((tile_id < TILESET_FIRST) && (kind == KIND_ABSENT));
    end
endmodule
`default_nettype wire

// ----- rtl/ttq_emit.sv -----
`default_nettype none
// Final stage: step through the quads of one item, one per cycle while out_ready allows.
module ttq_emit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ttq_pkg::quad_src_t     src,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        is_ground,
    output logic [6:0]                  above_layer,
    output logic [11:0]                 pos_x,
    output logic [11:0]                 pos_y,
    output logic [5:0]                  pos_w,
    output logic [5:0]                  pos_h,
    output logic [9:0]                  tex_x,
    output logic [15:0]                 tex_y,
    output logic signed [6:0]           tex_w,
    output logic signed [6:0]           tex_h,
    output logic                        last
);
    import ttq_pkg::*;

    quad_src_t   cur_reg;
    logic        busy_reg, busy_next;
    logic [1:0]  qi_reg, qi_next;
    logic        out_valid_reg, out_valid_next;
    logic        fin;
    logic [23:0] crow;
    logic [2:0]  cxh, cyh;
    logic [5:0]  ts2;
    logic [8:0]  txm;
    logic [8:0]  tym;
    logic        load;
    logic        adv;

    // result register: one quad, advance when free or taken
    assign adv      = !out_valid_reg || out_ready;
    assign fin      = (cur_reg.shape != SHAPE_QUARTERS) || (qi_reg == 2'd3);
    assign in_ready = adv && (!busy_reg || fin);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        crow = corner_row(cur_reg.pat);
        cxh  = crow[23 - 6*qi_reg -: 3];
        cyh  = crow[20 - 6*qi_reg -: 3];
        ts2  = {cur_reg.ts, 1'b0};
        txm  = 9'(cxh) * 9'(cur_reg.ts);
        tym  = 9'(cyh) * 9'(cur_reg.ts);
        busy_next      = busy_reg;
        qi_next        = qi_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                qi_next   = qi_reg + 2'd1;
                busy_next = !fin;
            end
            if (load)
            begin
                busy_next = 1'b1;
                qi_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            qi_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            qi_reg        <= qi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= src;
        end
        if (adv && busy_reg)
        begin
            is_ground   <= cur_reg.ground;
            above_layer <= cur_reg.layer;
            last        <= fin;
            unique case (cur_reg.shape)
                SHAPE_QUARTERS:
                begin
                    pos_x <= cur_reg.bx + (qi_reg[0] ? 12'(cur_reg.ts) : 12'd0);
                    pos_y <= cur_reg.by + (qi_reg[1] ? 12'(cur_reg.ts) : 12'd0);
                    pos_w <= 6'(cur_reg.ts);
                    pos_h <= 6'(cur_reg.ts);
                    tex_x <= 10'(txm) + 10'd1
                             + (cur_reg.shift_static ? 10'(ts2) * 10'd3 : 10'd0);
                    tex_y <= 16'(tym) + 16'd1 + cur_reg.yoff;
                    tex_w <= 7'(cur_reg.ts) - 7'sd2;
                    tex_h <= 7'(cur_reg.ts) - 7'sd2;
                end
                SHAPE_STRIP:
                begin
                    pos_x <= cur_reg.bx;
                    pos_y <= cur_reg.by;
                    pos_w <= ts2;
                    pos_h <= ts2;
                    tex_x <= 10'd1;
                    tex_y <= 16'd1 + cur_reg.yoff;
                    tex_w <= 7'(ts2) - 7'sd2;
                    tex_h <= 7'(ts2) - 7'sd2;
                end
                default:
                begin
                    pos_x <= cur_reg.bx;
                    pos_y <= cur_reg.by;
                    pos_w <= ts2;
                    pos_h <= ts2;
                    tex_x <= cur_reg.txcol + 10'd1;
                    tex_y <= cur_reg.tyrow + 16'd1;
                    tex_w <= 7'(ts2);
                    tex_h <= 7'(ts2);
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ----- rtl/tile_to_quad_expander_core.sv -----
`default_nettype none
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid / in_ready        | req_type tile_id cell_x cell_y priority_value
// out     | output    | out_valid / out_ready      | is_ground .. last (one quad)
// cfg     | input     | cfg_valid / cfg_ready      | cfg_index cfg_data
//
// Stages: decode (S1), priority RAM read with multiplies (S2), layer resolve (S3),
// quad emitter. An item passes the S1, S2 and S3 registers; the emitter then sends
// its quads one after another while out_ready allows, four for quarter-split autotile
// cells and one for single strip autotiles and tileset tiles. The first quad also passes
// the emitter's item and output registers. Reset clears the valid bits and emitter state
// and loads the config defaults; the priority table holds no reset value.
// A stall at out_ready holds the emitter, and S1..S3 once S3 is full; nothing drops or repeats.
module tile_to_quad_expander_core #(
    parameter int MAX_TILE_IDS = ttq_pkg::DEF_MAX_TILE_IDS,
    parameter int MAX_CELLS    = ttq_pkg::DEF_MAX_CELLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           req_type,
    input  wire logic [ttq_pkg::TILE_ID_W-1:0]  tile_id,
    input  wire logic [ttq_pkg::CELL_W-1:0]     cell_x,
    input  wire logic [ttq_pkg::CELL_W-1:0]     cell_y,
    input  wire logic [5:0]                     priority_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                is_ground,
    output logic [6:0]                          above_layer,
    output logic [11:0]                         pos_x,
    output logic [11:0]                         pos_y,
    output logic [5:0]                          pos_w,
    output logic [5:0]                          pos_h,
    output logic [9:0]                          tex_x,
    output logic [15:0]                         tex_y,
    output logic signed [6:0]                   tex_w,
    output logic signed [6:0]                   tex_h,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ttq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ttq_pkg::*;

    localparam int AW = $clog2(MAX_TILE_IDS);

    logic [TS_W-1:0]     ts_reg;
    logic [KINDS_W-1:0]  kinds_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    logic       s1_v_reg, s2_v_reg, s3_v_reg;
    dec_t       s1_reg, s2_reg;
    logic       s2_use_reg;
    logic [11:0] s2_bx_reg, s2_by_reg;
    logic [15:0] s2_yoff_reg, s2_tyrow_reg;
    logic [9:0]  s2_txcol_reg;
    quad_src_t  s3_reg;
    logic [PRIO_W-1:0] prio_rd;
    logic       dec_keep;
    dec_t       dec;
    logic       em_ready;
    logic       adv;
    logic       prio_wr;
    logic [4:0] ts_w;
    logic [PRIO_W-1:0] prio_eff;

    assign cfg_ready = 1'b1;

    // hold the register file; clamp tile size into 1..16
    always_comb
    begin
        ts_w = cfg_data[4:0];
        if (ts_w == 5'd0)
        begin
            ts_w = 5'd1;
        end
        else if (ts_w > 5'd16)
        begin
            ts_w = 5'd16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg     <= 5'd16;
            kinds_reg  <= '0;
            pcount_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TILE_SIZE:  ts_reg <= ts_w;
                CFG_KINDS:      kinds_reg <= cfg_data;
                CFG_PRIO_COUNT: pcount_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // the whole pipe advances together; the emitter is the only stall point
    assign adv      = !s3_v_reg || em_ready;
    assign in_ready = adv;
    assign prio_wr  = in_valid && (req_type == REQ_WRITE) && (32'(tile_id) < MAX_TILE_IDS);

    ttq_decode #(
        .MAX_TILE_IDS (MAX_TILE_IDS),
        .MAX_CELLS    (MAX_CELLS)
    ) u_decode (
        .req_type   (req_type),
        .tile_id    (tile_id),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .kinds      (kinds_reg),
        .prio_count (pcount_reg),
        .keep       (dec_keep),
        .dec        (dec)
    );

    // read the table while the item sits in S1, data lands with S2
    ttq_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (MAX_TILE_IDS)
    ) u_prio_ram (
        .clk   (clk),
        .we    (prio_wr && adv),
        .waddr (AW'(tile_id)),
        .wdata (priority_value > 6'd6 ? PRIO_HIDDEN : PRIO_W'(priority_value)),
        .re    (adv),
        .raddr (AW'(s1_reg.id)),
        .rdata (prio_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid && dec_keep;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && !(s2_use_reg && prio_rd > 3'd5);
        end
    end

    // S2: position and atlas products, one multiply each
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= dec;
            s2_reg       <= s1_reg;
            s2_use_reg   <= s1_reg.use_prio;
            s2_bx_reg    <= 12'(s1_reg.cx) * 12'({ts_reg, 1'b0});
            s2_by_reg    <= 12'(s1_reg.cy) * 12'({ts_reg, 1'b0});
            s2_yoff_reg  <= 16'({s1_reg.slot, 3'd0}) * 16'(ts_reg);
            s2_tyrow_reg <= 16'(s1_reg.trow) * 16'({ts_reg, 1'b0});
            s2_txcol_reg <= (10'(s1_reg.tcol) + 10'd12) * 10'({ts_reg, 1'b0});
        end
    end

    assign prio_eff = s2_use_reg ? prio_rd : 3'd0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg.ground       <= (prio_eff == 3'd0);
            s3_reg.layer        <= (prio_eff == 3'd0) ? 7'd0
                                   : 7'(s2_reg.cy) + 7'(prio_eff);
            s3_reg.shape        <= s2_reg.shape;
            s3_reg.shift_static <= s2_reg.shift_static;
            s3_reg.pat          <= s2_reg.pat;
            s3_reg.bx           <= s2_bx_reg;
            s3_reg.by           <= s2_by_reg;
            s3_reg.ts           <= ts_reg;
            s3_reg.yoff         <= s2_yoff_reg;
            s3_reg.tyrow        <= s2_tyrow_reg;
            s3_reg.txcol        <= s2_txcol_reg;
        end
    end

    ttq_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s3_v_reg),
        .in_ready    (em_ready),
        .src         (s3_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_ground   (is_ground),
        .above_layer (above_layer),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_w       (pos_w),
        .pos_h       (pos_h),
        .tex_x       (tex_x),
        .tex_y       (tex_y),
        .tex_w       (tex_w),
        .tex_h       (tex_h),
        .last        (last)
    );
endmodule
`default_nettype wire
